[sv/gsge_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsge_pkg: shared types and constants
// Item structs, register indexes, fixed-point widths and the 2^-x table.
// ----------------------------------------------------------------------------
package gsge_pkg;

    // Input item: one grid point
    typedef struct packed {
        logic [5:0] cell_x;
        logic [5:0] cell_y;
        logic [5:0] cell_z;
        logic       mirror_x;
        logic       mirror_y;
        logic       mirror_z;
    } point_t;

    // Result item
    typedef struct packed {
        logic [31:0] density;
        logic        underflow;
    } result_t;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Z  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_NORM     = 3'd6;

    // Fixed-point widths
    localparam int MAG_W  = 16;   // |d| in Q8.8
    localparam int TERM_W = 24;   // axis term in Q.16
    localparam int SQ_W   = 48;   // squared term in Q.32
    localparam int SUM_W  = 50;
    localparam int S_W    = 37;   // s below 23.0 in Q.32
    localparam int S_LO_W = 20;
    localparam int S_HI_W = S_W - S_LO_W;
    localparam int LOG2E_W = 25;
    localparam logic [LOG2E_W-1:0] LOG2E_Q24 = 25'd24204406;
    localparam int Y_W    = 38;
    localparam logic [SUM_W-1:0] ARG_LIMIT = 50'd23 << 32;
    localparam logic [Y_W-1:0]   Y_LIMIT   = 38'd32 << 32;

    // Exponent table
    localparam int EXP_TABLE_BITS = 8;
    localparam int EXP_TABLE_SIZE = (1 << EXP_TABLE_BITS) + 1;
    localparam int FRAC_BITS      = 32 - EXP_TABLE_BITS;
    localparam int SHIFT_W        = Y_W - 32;

    typedef logic [32:0] exp_tab_t [EXP_TABLE_SIZE];

    // Truncating integer square root
    function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] bitv;
        x    = x_in;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (bitv > x)
                bitv = bitv >> 2;
        end
        for (int i = 0; i < 32; i++)
        begin
            if (bitv != 0)
            begin
                if (x >= res + bitv)
                begin
                    x   = x - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return res;
    endfunction

    // 2^-(k/2^EXP_TABLE_BITS) in Q0.32, from repeated roots of one half
    function automatic exp_tab_t build_exp_tab();
        exp_tab_t    tab;
        logic [63:0] roots [EXP_TABLE_BITS+1];
        logic [63:0] acc;
        roots[0] = 64'd1 << 31;
        for (int j = 1; j <= EXP_TABLE_BITS; j++)
            roots[j] = isqrt64(roots[j-1] << 32);
        for (int k = 0; k < EXP_TABLE_SIZE - 1; k++)
        begin
            acc = 64'd1 << 32;
            for (int b = 0; b < EXP_TABLE_BITS; b++)
            begin
                if (((k >> b) & 1) != 0)
                    acc = (acc * roots[EXP_TABLE_BITS-b] + (64'd1 << 31)) >> 32;
            end
            tab[k] = acc[32:0];
        end
        tab[EXP_TABLE_SIZE-1] = 33'd1 << 31;
        return tab;
    endfunction

    localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage
`default_nettype wire

[sv/gsge_axis.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsge_axis: squared axis term
// Three stages: centre minus offset, scaling with rounding, squaring.
// ----------------------------------------------------------------------------
module gsge_axis (
    input  wire logic                      clk,
    input  wire logic [5:0]                cell_idx,
    input  wire logic                      mirror,
    input  wire logic signed [15:0]        offset,
    input  wire logic [15:0]               scale,
    output logic [gsge_pkg::SQ_W-1:0]      sq
);
    import gsge_pkg::*;

    logic signed [17:0] c_s;
    logic signed [17:0] d_s;
    logic [MAG_W-1:0]   mag_next, mag_reg;
    logic [31:0]        prod;
    logic [TERM_W-1:0]  a_next, a_reg;
    logic [SQ_W-1:0]    sq_next, sq_reg;

    // Stage 1: signed distance in Q8.8, magnitude
    always_comb
    begin
        c_s = $signed({4'b0000, cell_idx, 8'h80});
        if (mirror)
            c_s = -c_s;
        d_s = c_s - $signed({{2{offset[15]}}, offset});
        mag_next = d_s[17] ? 16'(-d_s) : d_s[15:0];
    end

    // Stage 2: scale, round half up to Q.16
    assign prod   = 32'(scale) * 32'(mag_reg) + 32'd128;
    assign a_next = prod[31:8];

    // Stage 3: square
    assign sq_next = 48'(a_reg) * 48'(a_reg);

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        a_reg   <= a_next;
        sq_reg  <= sq_next;
    end

    assign sq = sq_reg;

endmodule
`default_nettype wire

[sv/gsge_exp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsge_exp: exp(-s) as 2^-y
// Sum of squares, scaling by log2(e), table lookup, interpolation, shift.
// ----------------------------------------------------------------------------
module gsge_exp (
    input  wire logic                      clk,
    input  wire logic [gsge_pkg::SQ_W-1:0] sq_x,
    input  wire logic [gsge_pkg::SQ_W-1:0] sq_y,
    input  wire logic [gsge_pkg::SQ_W-1:0] sq_z,
    output logic [32:0]                    value,
    output logic                           uflow
);
    import gsge_pkg::*;

    logic [SUM_W-1:0]              sum;
    logic [S_W-1:0]                s_reg;
    logic                          uf1_reg, uf2_reg, uf3_reg, uf4_reg, uf5_reg, uf6_reg;
    logic [S_LO_W+LOG2E_W-1:0]     pp_lo_reg;
    logic [S_HI_W+LOG2E_W-1:0]     pp_hi_reg;
    logic [61:0]                   yprod;
    logic [Y_W-1:0]                y_next, y_reg;
    logic [EXP_TABLE_BITS-1:0]     idx;
    logic [EXP_TABLE_BITS:0]       idx1;
    logic [32:0]                   t0, t1;
    logic [32:0]                   t0_reg;
    logic [31:0]                   diff_reg;
    logic [FRAC_BITS-1:0]          frac_reg;
    logic [SHIFT_W-1:0]            n4_reg, n5_reg;
    logic [31+FRAC_BITS:0]         iprod;
    logic [32:0]                   v_reg;
    logic [32:0]                   value_reg;

    // Stage 1: sum of squares, range check
    assign sum = 50'(sq_x) + 50'(sq_y) + 50'(sq_z);

    // Stage 3: join partial products, round to Q.32
    assign yprod  = 62'(pp_lo_reg) + (62'(pp_hi_reg) << S_LO_W) + (62'd1 << 23);
    assign y_next = yprod[61:24];

    // Stage 4: table reads
    assign idx  = y_reg[31 -: EXP_TABLE_BITS];
    assign idx1 = (EXP_TABLE_BITS+1)'(idx) + 1'b1;
    assign t0   = EXP_TAB[idx];
    assign t1   = EXP_TAB[idx1];

    // Stage 5: interpolation product
    assign iprod = diff_reg * frac_reg;

    always_ff @(posedge clk)
    begin
        s_reg     <= sum[S_W-1:0];
        uf1_reg   <= (sum >= ARG_LIMIT);
        // split multiply by log2(e)
        pp_lo_reg <= s_reg[S_LO_W-1:0] * LOG2E_Q24;
        pp_hi_reg <= s_reg[S_W-1:S_LO_W] * LOG2E_Q24;
        uf2_reg   <= uf1_reg;
        y_reg     <= y_next;
        uf3_reg   <= uf2_reg | (y_next > Y_LIMIT);
        t0_reg    <= t0;
        diff_reg  <= 32'(t0 - t1);
        frac_reg  <= y_reg[FRAC_BITS-1:0];
        n4_reg    <= y_reg[Y_W-1:32];
        uf4_reg   <= uf3_reg;
        v_reg     <= t0_reg - 33'(iprod >> FRAC_BITS);
        n5_reg    <= n4_reg;
        uf5_reg   <= uf4_reg;
        // integer part of y as right shift
        value_reg <= v_reg >> n5_reg;
        uf6_reg   <= uf5_reg;
    end

    assign value = value_reg;
    assign uflow = uf6_reg;

endmodule
`default_nettype wire

[sv/gaussian_source_grid_eval.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gaussian_source_grid_eval: anisotropic 3-D Gaussian at one grid point
// Returns norm_scale * exp(-(ax^2 + ay^2 + az^2)) per point; exp is Q0.32.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive point and raise start; the item is taken at each edge with
//   start high and busy low. busy is always low, so a point may enter in
//   every cycle.
//   Output: done is high for one cycle with result valid; the result is
//   taken at the edge that ends that cycle. The receiver cannot stall and
//   needs none: results leave in input order, one per accepted point.
//   Valid: done comes from a valid shift register that runs in step with the
//   datapath registers, so it rises together with each new result.
//   Throughput: one item per cycle; each of the 11 register stages (three
//   axis stages, six exponent stages, norm multiply and output register)
//   takes a new item every cycle.
//   Config: cfg_we, cfg_index, cfg_data write one register per edge; write
//   only while no item is in flight. Indexes past norm_scale are ignored.
//   Reset: rst_n clears the pipeline valid bits and loads register defaults
//   (offsets 0, scales 4096, norm_scale 1506600). No clearing pass.
// ----------------------------------------------------------------------------
module gaussian_source_grid_eval (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire gsge_pkg::point_t               point,
    output logic                                done,
    output gsge_pkg::result_t                   result,
    input  wire logic                           cfg_we,
    input  wire logic [gsge_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [gsge_pkg::CFG_DATA_W-1:0] cfg_data
);
    import gsge_pkg::*;

    localparam int LAT = 11;

    logic signed [15:0] off_x_reg, off_y_reg, off_z_reg;
    logic [15:0]        scale_x_reg, scale_y_reg, scale_z_reg;
    logic [31:0]        norm_reg;
    logic [LAT-1:0]     valid_reg;
    logic [SQ_W-1:0]    sq_x, sq_y, sq_z;
    logic [32:0]        value;
    logic               uflow;
    logic [63:0]        prod_reg;
    logic               one_reg, uf7_reg;
    logic [63:0]        rnd;
    result_t            result_next, result_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_x_reg   <= '0;
            off_y_reg   <= '0;
            off_z_reg   <= '0;
            scale_x_reg <= 16'd4096;
            scale_y_reg <= 16'd4096;
            scale_z_reg <= 16'd4096;
            norm_reg    <= 32'd1506600;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OFFSET_X: off_x_reg   <= cfg_data[15:0];
                CFG_OFFSET_Y: off_y_reg   <= cfg_data[15:0];
                CFG_OFFSET_Z: off_z_reg   <= cfg_data[15:0];
                CFG_SCALE_X:  scale_x_reg <= cfg_data[15:0];
                CFG_SCALE_Y:  scale_y_reg <= cfg_data[15:0];
                CFG_SCALE_Z:  scale_z_reg <= cfg_data[15:0];
                CFG_NORM:     norm_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Valid bits travel alongside the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[LAT-2:0], start};
    end

    assign busy = 1'b0;

    // Axis terms
    gsge_axis u_axis_x (
        .clk      (clk),
        .cell_idx (point.cell_x),
        .mirror   (point.mirror_x),
        .offset   (off_x_reg),
        .scale    (scale_x_reg),
        .sq       (sq_x)
    );

    gsge_axis u_axis_y (
        .clk      (clk),
        .cell_idx (point.cell_y),
        .mirror   (point.mirror_y),
        .offset   (off_y_reg),
        .scale    (scale_y_reg),
        .sq       (sq_y)
    );

    gsge_axis u_axis_z (
        .clk      (clk),
        .cell_idx (point.cell_z),
        .mirror   (point.mirror_z),
        .offset   (off_z_reg),
        .scale    (scale_z_reg),
        .sq       (sq_z)
    );

    // Exponential
    gsge_exp u_exp (
        .clk   (clk),
        .sq_x  (sq_x),
        .sq_y  (sq_y),
        .sq_z  (sq_z),
        .value (value),
        .uflow (uflow)
    );

    // Normalization: value of exactly 1.0 passes norm_scale through
    assign rnd = prod_reg + (64'd1 << 31);

    always_comb
    begin
        result_next.underflow = uf7_reg;
        if (uf7_reg)
            result_next.density = '0;
        else if (one_reg)
            result_next.density = norm_reg;
        else
            result_next.density = rnd[63:32];
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= 64'(norm_reg) * 64'(value[31:0]);
        one_reg    <= value[32];
        uf7_reg    <= uflow;
        result_reg <= result_next;
    end

    assign done   = valid_reg[LAT-1];
    assign result = result_reg;

endmodule
`default_nettype wire
